/* design/e2q_pkg.sv */
// shared constants, types and the arctangent table for the euler to quaternion core
`timescale 1ns / 1ps
`default_nettype none

package e2q_pkg;

   // default parameter values
   localparam int ANGLE_BITS_DEF     = 16;
   localparam int COMPONENT_BITS_DEF = 16;
   localparam int CORDIC_STAGES_DEF  = 14;

   // internal widths: angles and cordic x/y in q30 with headroom, cos/sin in q30
   localparam int Z_W    = 34;
   localparam int XY_W   = 34;
   localparam int TRIG_W = 32;
   localparam int PROD_W = 2 * TRIG_W;
   localparam int ATAN_ENTRIES = 30;

   // q30 constants
   localparam logic signed [XY_W-1:0] GAIN_Q30    = 34'sd652032874;
   localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [Z_W-1:0]  PI_Q30      = 34'sd3373259426;
   localparam logic signed [PROD_W-1:0] Q30_ROUND = 64'sd536870912;

   // cosine and sine of the three half angles
   typedef struct packed {
      logic signed [TRIG_W-1:0] cr;
      logic signed [TRIG_W-1:0] sr;
      logic signed [TRIG_W-1:0] cp;
      logic signed [TRIG_W-1:0] sp;
      logic signed [TRIG_W-1:0] cy;
      logic signed [TRIG_W-1:0] sy;
   } e2q_trig_type;

   // atan(2^-i) in q30, truncated
   function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         0:  val = 34'sd843314856;
         1:  val = 34'sd497837829;
         2:  val = 34'sd263043836;
         3:  val = 34'sd133525158;
         4:  val = 34'sd67021686;
         5:  val = 34'sd33543515;
         6:  val = 34'sd16775850;
         7:  val = 34'sd8388437;
         8:  val = 34'sd4194282;
         9:  val = 34'sd2097149;
         10: val = 34'sd1048575;
         11: val = 34'sd524287;
         12: val = 34'sd262143;
         13: val = 34'sd131071;
         14: val = 34'sd65535;
         15: val = 34'sd32767;
         16: val = 34'sd16383;
         17: val = 34'sd8191;
         18: val = 34'sd4095;
         19: val = 34'sd2047;
         20: val = 34'sd1023;
         21: val = 34'sd511;
         22: val = 34'sd255;
         23: val = 34'sd127;
         24: val = 34'sd63;
         25: val = 34'sd31;
         26: val = 34'sd15;
         27: val = 34'sd7;
         28: val = 34'sd3;
         29: val = 34'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

/* design/e2q_cordic.sv */
// three-lane pipelined cordic giving cosine and sine of the half angles
`timescale 1ns / 1ps
`default_nettype none

module e2q_cordic import e2q_pkg::*; #(
   parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic [2:0][ANGLE_BITS-1:0] angles,     // roll, pitch, yaw from lane 0 up
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output e2q_trig_type                    trig
);

   // fold stage, one stage per iteration, output stage
   localparam int NS = CORDIC_STAGES + 2;
   localparam int HS = 32 - ANGLE_BITS;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS:0]   en;

   logic signed [Z_W-1:0] half [3];
   logic signed [Z_W-1:0] z0_in [3];
   logic signed [Z_W-1:0] z0_ff [3];
   logic [2:0]            flip0_in;
   logic [2:0]            flip0_ff;

   logic signed [XY_W-1:0] x_in [CORDIC_STAGES][3];
   logic signed [XY_W-1:0] x_ff [CORDIC_STAGES][3];
   logic signed [XY_W-1:0] y_in [CORDIC_STAGES][3];
   logic signed [XY_W-1:0] y_ff [CORDIC_STAGES][3];
   logic signed [Z_W-1:0]  z_in [CORDIC_STAGES][3];
   logic signed [Z_W-1:0]  z_ff [CORDIC_STAGES][3];
   logic [2:0]             flip_ff [CORDIC_STAGES];

   logic signed [TRIG_W-1:0] cos_l [3];
   logic signed [TRIG_W-1:0] sin_l [3];
   e2q_trig_type             trig_in;
   e2q_trig_type             trig_ff;

   // ready chain: a stage loads when it is empty or its successor moves
   assign en[NS] = out_ready;
   for (genvar k = 0; k < NS; k++) begin : g_en
      assign en[k] = !vld_ff[k] || en[k+1];
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[NS-1];

   always_comb begin
      vld_in[0] = in_valid;
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // halve the angle into q30 and fold it into plus or minus pi/2
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         half[l] = $signed({{(Z_W-ANGLE_BITS){angles[l][ANGLE_BITS-1]}}, angles[l]}) <<< HS;
         if (half[l] > HALF_PI_Q30) begin
            z0_in[l]    = half[l] - PI_Q30;
            flip0_in[l] = 1'b1;
         end else if (half[l] < -HALF_PI_Q30) begin
            z0_in[l]    = half[l] + PI_Q30;
            flip0_in[l] = 1'b1;
         end else begin
            z0_in[l]    = half[l];
            flip0_in[l] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         z0_ff    <= z0_in;
         flip0_ff <= flip0_in;
      end
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      logic signed [XY_W-1:0] px [3];
      logic signed [XY_W-1:0] py [3];
      logic signed [Z_W-1:0]  pz [3];
      logic [2:0]             pflip;

      if (i == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               px[l] = GAIN_Q30;
               py[l] = '0;
               pz[l] = z0_ff[l];
            end
            pflip = flip0_ff;
         end
      end else begin : g_next
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               px[l] = x_ff[i-1][l];
               py[l] = y_ff[i-1][l];
               pz[l] = z_ff[i-1][l];
            end
            pflip = flip_ff[i-1];
         end
      end

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            if (!pz[l][Z_W-1]) begin
               x_in[i][l] = px[l] - (py[l] >>> i);
               y_in[i][l] = py[l] + (px[l] >>> i);
               z_in[i][l] = pz[l] - atan_q30(i);
            end else begin
               x_in[i][l] = px[l] + (py[l] >>> i);
               y_in[i][l] = py[l] - (px[l] >>> i);
               z_in[i][l] = pz[l] + atan_q30(i);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[i+1]) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            z_ff[i]    <= z_in[i];
            flip_ff[i] <= pflip;
         end
      end
   end

   // undo the fold by negating cosine and sine
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (flip_ff[CORDIC_STAGES-1][l]) begin
            cos_l[l] = TRIG_W'(-x_ff[CORDIC_STAGES-1][l]);
            sin_l[l] = TRIG_W'(-y_ff[CORDIC_STAGES-1][l]);
         end else begin
            cos_l[l] = TRIG_W'(x_ff[CORDIC_STAGES-1][l]);
            sin_l[l] = TRIG_W'(y_ff[CORDIC_STAGES-1][l]);
         end
      end
      trig_in.cr = cos_l[0];
      trig_in.sr = sin_l[0];
      trig_in.cp = cos_l[1];
      trig_in.sp = sin_l[1];
      trig_in.cy = cos_l[2];
      trig_in.sy = sin_l[2];
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         trig_ff <= trig_in;
      end
   end

   assign trig = trig_ff;

   // folded angle stays within plus or minus pi/2
   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |->
         (z0_ff[0] <= HALF_PI_Q30) && (z0_ff[0] >= -HALF_PI_Q30) &&
         (z0_ff[1] <= HALF_PI_Q30) && (z0_ff[1] >= -HALF_PI_Q30) &&
         (z0_ff[2] <= HALF_PI_Q30) && (z0_ff[2] >= -HALF_PI_Q30))
      else $error("folded half angle out of range");

   // an accepted word lands in the fold stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> vld_ff[0])
      else $error("accepted word lost at fold stage");

endmodule

`default_nettype wire

/* design/e2q_quat.sv */
// pipelined product, sum, rounding and saturation forming the quaternion
`timescale 1ns / 1ps
`default_nettype none

module e2q_quat import e2q_pkg::*; #(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire e2q_trig_type                  trig,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [3:0][COMPONENT_BITS-1:0]     quat      // x, y, z, w from lane 0 up
);

   localparam int NS    = 6;
   localparam int FRAC  = COMPONENT_BITS - 2;
   localparam int SH    = 60 - FRAC;
   localparam int SUM_W = PROD_W + 1;
   localparam int RND_W = SUM_W + 1;
   localparam logic signed [RND_W-1:0] ROUND_C = RND_W'(1) <<< (SH - 1);
   localparam logic signed [RND_W-1:0] ONE_R   = RND_W'(1) <<< FRAC;
   localparam logic signed [COMPONENT_BITS-1:0] ONE_C = COMPONENT_BITS'(1) <<< FRAC;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS:0]   en;

   // stage payloads
   logic signed [TRIG_W-1:0] cr0_ff, sr0_ff, cr1_ff, sr1_ff;
   logic signed [PROD_W-1:0] p0_in [4];
   logic signed [PROD_W-1:0] p0_ff [4];
   logic signed [TRIG_W-1:0] q1_in [4];
   logic signed [TRIG_W-1:0] q1_ff [4];
   logic signed [PROD_W-1:0] ta2_in [4];
   logic signed [PROD_W-1:0] tb2_in [4];
   logic signed [PROD_W-1:0] ta2_ff [4];
   logic signed [PROD_W-1:0] tb2_ff [4];
   logic signed [SUM_W-1:0]  s3_in [4];
   logic signed [SUM_W-1:0]  s3_ff [4];
   logic signed [RND_W-1:0]  r4_in [4];
   logic signed [RND_W-1:0]  r4_ff [4];
   logic signed [COMPONENT_BITS-1:0] q5_in [4];
   logic signed [COMPONENT_BITS-1:0] q5_ff [4];

   // ready chain
   assign en[NS] = out_ready;
   for (genvar k = 0; k < NS; k++) begin : g_en
      assign en[k] = !vld_ff[k] || en[k+1];
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[NS-1];

   always_comb begin
      vld_in[0] = in_valid;
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // pitch and yaw pair products
   always_comb begin
      p0_in[0] = trig.cp * trig.cy;
      p0_in[1] = trig.sp * trig.sy;
      p0_in[2] = trig.cp * trig.sy;
      p0_in[3] = trig.sp * trig.cy;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p0_ff  <= p0_in;
         cr0_ff <= trig.cr;
         sr0_ff <= trig.sr;
      end
   end

   // round pair products back to q30
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         q1_in[c] = TRIG_W'((p0_ff[c] + Q30_ROUND) >>> 30);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         q1_ff  <= q1_in;
         cr1_ff <= cr0_ff;
         sr1_ff <= sr0_ff;
      end
   end

   // roll terms at q60: q1 holds cpcy, spsy, cpsy, spcy
   always_comb begin
      ta2_in[0] = sr1_ff * q1_ff[0];
      tb2_in[0] = cr1_ff * q1_ff[1];
      ta2_in[1] = cr1_ff * q1_ff[3];
      tb2_in[1] = sr1_ff * q1_ff[2];
      ta2_in[2] = cr1_ff * q1_ff[2];
      tb2_in[2] = sr1_ff * q1_ff[3];
      ta2_in[3] = cr1_ff * q1_ff[0];
      tb2_in[3] = sr1_ff * q1_ff[1];
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         ta2_ff <= ta2_in;
         tb2_ff <= tb2_in;
      end
   end

   // x and z take a difference, y and w a sum
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         if (c == 0 || c == 2) begin
            s3_in[c] = SUM_W'(ta2_ff[c]) - SUM_W'(tb2_ff[c]);
         end else begin
            s3_in[c] = SUM_W'(ta2_ff[c]) + SUM_W'(tb2_ff[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_ff <= s3_in;
      end
   end

   // round half up to the output fraction
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         r4_in[c] = (RND_W'(s3_ff[c]) + ROUND_C) >>> SH;
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         r4_ff <= r4_in;
      end
   end

   // saturate to plus or minus one
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         if (r4_ff[c] > ONE_R) begin
            q5_in[c] = ONE_C;
         end else if (r4_ff[c] < -ONE_R) begin
            q5_in[c] = -ONE_C;
         end else begin
            q5_in[c] = COMPONENT_BITS'(r4_ff[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         q5_ff <= q5_in;
      end
   end

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         quat[c] = q5_ff[c];
      end
   end

   // delivered components stay within plus or minus one
   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |->
         (q5_ff[0] <= ONE_C) && (q5_ff[0] >= -ONE_C) &&
         (q5_ff[1] <= ONE_C) && (q5_ff[1] >= -ONE_C) &&
         (q5_ff[2] <= ONE_C) && (q5_ff[2] >= -ONE_C) &&
         (q5_ff[3] <= ONE_C) && (q5_ff[3] >= -ONE_C))
      else $error("quaternion component beyond saturation limit");

   // a word taken from the cordic enters the product stage
   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> vld_ff[0])
      else $error("word from cordic lost at product stage");

endmodule

`default_nettype wire

/* design/euler_to_quaternion_core.sv */
// top level: euler angles to rotation quaternion, cordic and product pipelines
//
//   channel   direction  ports           payload
//   req       in         req_t*          roll, pitch, yaw angles, signed q2.13
//   rsp       out        rsp_t*          quaternion x, y, z, w, signed q1.14
//
// one word enters per cycle while rsp is ready; the unrolled cordic (fold, one stage
// per iteration, sign fix) is followed by six product stages.
// reset clears only the stage valid bits; no state outlives a word.
// a stalled rsp holds its word; each stage loads while it or its successor can
// move, so bubbles close up and req stays ready until the pipeline is full.
`timescale 1ns / 1ps
`default_nettype none

module euler_to_quaternion_core import e2q_pkg::*; #(
   parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
   parameter int CORDIC_STAGES  = CORDIC_STAGES_DEF
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        req_tvalid,
   output logic                                             req_tready,
   // roll_angle, pitch_angle, yaw_angle, zero fill
   input  wire logic [((3*ANGLE_BITS+7)/8)*8-1:0]           req_tdata,
   output logic                                             rsp_tvalid,
   input  wire logic                                        rsp_tready,
   // quat_x, quat_y, quat_z, quat_w, zero fill
   output logic [((4*COMPONENT_BITS+7)/8)*8-1:0]            rsp_tdata
);

   localparam int OUT_W = ((4*COMPONENT_BITS+7)/8)*8;

   logic [2:0][ANGLE_BITS-1:0]     angles;
   logic [3:0][COMPONENT_BITS-1:0] quat;
   e2q_trig_type                   trig;
   logic                           trig_valid;
   logic                           trig_ready;

   // unpack the angle word
   assign angles = req_tdata[3*ANGLE_BITS-1:0];

   e2q_cordic #(
      .ANGLE_BITS    (ANGLE_BITS),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .angles    (angles),
      .out_valid (trig_valid),
      .out_ready (trig_ready),
      .trig      (trig)
   );

   e2q_quat #(
      .COMPONENT_BITS (COMPONENT_BITS)
   ) u_quat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (trig_valid),
      .in_ready  (trig_ready),
      .trig      (trig),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .quat      (quat)
   );

   // pack the result word with zero fill
   assign rsp_tdata = OUT_W'(quat);

   // an empty output stage means the whole ready chain is open
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output stage empty");

endmodule

`default_nettype wire

/* tb/e2q_quat_checker.sv */
// watches the angle and quaternion streams, predicts each quaternion and compares
`timescale 1ns / 1ps

module e2q_quat_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   // roll_angle, pitch_angle, yaw_angle
   input  wire logic [47:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // quat_x, quat_y, quat_z, quat_w
   input  wire logic [63:0] rsp_tdata,
   output int               mismatch_count,
   output int               words_pending,
   output int               words_checked
);

   localparam int     STAGES      = 14;
   localparam longint CORDIC_GAIN = 64'sd652032874;
   localparam longint HALF_PI     = 64'sd1686629713;
   localparam longint FULL_PI     = 64'sd3373259426;
   localparam longint UNIT_Q14    = 64'sd16384;

   // first field in the lowest bits
   typedef struct packed {
      logic signed [15:0] yaw;
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
   } angles_t;

   typedef struct packed {
      logic signed [15:0] w;
      logic signed [15:0] z;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } quat_t;

   quat_t expected_quats[$];
   int    fail_tally  = 0;
   int    check_tally = 0;

   // atan(2^-i) in q30, truncated
   function automatic longint arctan_q30(input int idx);
      case (idx)
         0:  return 64'sd843314856;
         1:  return 64'sd497837829;
         2:  return 64'sd263043836;
         3:  return 64'sd133525158;
         4:  return 64'sd67021686;
         5:  return 64'sd33543515;
         6:  return 64'sd16775850;
         7:  return 64'sd8388437;
         8:  return 64'sd4194282;
         9:  return 64'sd2097149;
         10: return 64'sd1048575;
         11: return 64'sd524287;
         12: return 64'sd262143;
         13: return 64'sd131071;
         default: return 64'sd0;
      endcase
   endfunction

   // cosine and sine of half the angle, q30, with the quadrant fold
   function automatic void half_angle_trig(input logic signed [15:0] ang,
                                           output longint cos_h, output longint sin_h);
      longint z;
      longint vx;
      longint vy;
      longint dx;
      longint dy;
      bit     flip;
      z    = longint'(ang) <<< 16;
      vx   = CORDIC_GAIN;
      vy   = 0;
      flip = 1'b0;
      if (z > HALF_PI) begin
         z    = z - FULL_PI;
         flip = 1'b1;
      end else if (z < -HALF_PI) begin
         z    = z + FULL_PI;
         flip = 1'b1;
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (z >= 0) begin
            vx = vx - dx;
            vy = vy + dy;
            z  = z - arctan_q30(i);
         end else begin
            vx = vx + dx;
            vy = vy - dy;
            z  = z + arctan_q30(i);
         end
      end
      cos_h = flip ? -vx : vx;
      sin_h = flip ? -vy : vy;
   endfunction

   // q30 by q30, rounded back to q30
   function automatic longint mul_q30_round(input longint a, input longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   // q60 to q1.14, half up, saturated to plus or minus one
   function automatic logic signed [15:0] round_component(input longint q60);
      longint r;
      r = (q60 + (64'sd1 <<< 45)) >>> 46;
      if (r > UNIT_Q14)
         r = UNIT_Q14;
      if (r < -UNIT_Q14)
         r = -UNIT_Q14;
      return r[15:0];
   endfunction

   function automatic quat_t predict_quat(input angles_t a);
      longint cr, sr, cp, sp, cy, sy;
      longint cpcy, spsy, cpsy, spcy;
      quat_t  q;
      half_angle_trig(a.roll, cr, sr);
      half_angle_trig(a.pitch, cp, sp);
      half_angle_trig(a.yaw, cy, sy);
      cpcy = mul_q30_round(cp, cy);
      spsy = mul_q30_round(sp, sy);
      cpsy = mul_q30_round(cp, sy);
      spcy = mul_q30_round(sp, cy);
      q.x  = round_component(sr * cpcy - cr * spsy);
      q.y  = round_component(cr * spcy + sr * cpsy);
      q.z  = round_component(cr * cpsy - sr * spcy);
      q.w  = round_component(cr * cpcy + sr * spsy);
      return q;
   endfunction

   task automatic compare_field(input string name, input logic signed [15:0] want,
                                input logic signed [15:0] seen);
      if (seen !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
         fail_tally++;
      end
   endtask

   // results first: a word accepted this edge cannot already have its result
   always @(posedge clock) begin
      quat_t seen;
      quat_t want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen = quat_t'(rsp_tdata);
            if (expected_quats.size() == 0) begin
               $error("quaternion word with none expected: %h", rsp_tdata);
               fail_tally++;
            end else begin
               want = expected_quats.pop_front();
               compare_field("quat_x", want.x, seen.x);
               compare_field("quat_y", want.y, seen.y);
               compare_field("quat_z", want.z, seen.z);
               compare_field("quat_w", want.w, seen.w);
               check_tally++;
            end
         end
         if (req_tvalid && req_tready)
            expected_quats.push_back(predict_quat(angles_t'(req_tdata)));
         words_pending  <= expected_quats.size();
         mismatch_count <= fail_tally;
         words_checked  <= check_tally;
      end
   end

endmodule

/* tb/euler_to_quaternion_core_tb.sv */
// stimulus, flow control and verdict for the euler to quaternion core
`timescale 1ns / 1ps

module euler_to_quaternion_core_tb;

   localparam int PIPE_LATENCY = e2q_pkg::CORDIC_STAGES_DEF + 8;
   localparam int RANDOM_WORDS = 650;
   localparam int FOLD_EDGE    = 25736;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // roll_angle, pitch_angle, yaw_angle
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // quat_x, quat_y, quat_z, quat_w
   logic [63:0] rsp_tdata;

   int mismatch_count;
   int words_pending;
   int words_checked;
   int words_sent     = 0;
   int directed_words = 0;
   bit steady_flow    = 1'b0;

   euler_to_quaternion_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   e2q_quat_checker quat_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending),
      .words_checked  (words_checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // one angle word, after a random gap unless the flow is steady
   task automatic send_angles(input logic [15:0] roll, input logic [15:0] pitch,
                              input logic [15:0] yaw);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {yaw, pitch, roll};
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // hold off until every quaternion in flight has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
   endtask

   // mostly uniform, with weight on the extremes, the fold edge and small angles
   function automatic logic [15:0] pick_angle();
      int v;
      case ($urandom_range(0, 9))
         0: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
         1: begin
            v = FOLD_EDGE - 8 + $urandom_range(0, 16);
            if ($urandom_range(0, 1) != 0)
               v = -v;
         end
         2: v = $urandom_range(0, 512) - 256;
         default: v = $urandom;
      endcase
      return v[15:0];
   endfunction

   // result side stalls
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes of every field
      send_angles(16'sd0, 16'sd0, 16'sd0);
      send_angles(16'sd32767, 16'sd32767, 16'sd32767);
      send_angles(-16'sd32768, -16'sd32768, -16'sd32768);
      send_angles(16'sd32767, -16'sd32768, 16'sd0);
      send_angles(16'sd0, 16'sd32767, -16'sd32768);
      send_angles(-16'sd32768, 16'sd0, 16'sd32767);
      // half angle just inside and just past plus and minus pi/2
      send_angles(16'sd25735, 16'sd0, 16'sd0);
      send_angles(16'sd25736, 16'sd0, 16'sd0);
      send_angles(-16'sd25735, 16'sd0, 16'sd0);
      send_angles(-16'sd25736, 16'sd0, 16'sd0);
      send_angles(16'sd0, 16'sd25736, 16'sd0);
      send_angles(16'sd0, 16'sd0, -16'sd25736);
      send_angles(16'sd25736, 16'sd25736, 16'sd25736);
      // gimbal lock, pitch at plus or minus pi/2
      send_angles(16'sd0, 16'sd12868, 16'sd0);
      send_angles(16'sd0, -16'sd12868, 16'sd0);
      send_angles(16'sd8192, 16'sd12868, -16'sd8192);
      // one radian about each axis, and the smallest steps
      send_angles(16'sd8192, 16'sd0, 16'sd0);
      send_angles(16'sd0, -16'sd8192, 16'sd0);
      send_angles(16'sd0, 16'sd0, 16'sd8192);
      send_angles(16'sd1, -16'sd1, 16'sd1);
      directed_words = words_sent;
      drain_results();

      // random part, with steady stretches and a drain halfway
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 64 == 0)
            steady_flow = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_WORDS / 2)
            drain_results();
         send_angles(pick_angle(), pick_angle(), pick_angle());
      end
      steady_flow = 1'b0;
      drain_results();
      repeat (PIPE_LATENCY + 4) @(posedge clock);

      $display("covered %0d angle words (%0d directed, the rest random with stalls)",
               words_sent, directed_words);
      $display("checked %0d quaternion words field by field", words_checked);
      if (mismatch_count == 0)
         $display("[euler_to_quaternion_core] OK");
      else
         $display("[euler_to_quaternion_core] ERROR");
      $finish;
   end

   // run limit
   initial begin
      #400000;
      $display("[euler_to_quaternion_core] ERROR");
      $finish;
   end

endmodule
